// ----- hdl/iox_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iox_pkg
// Types and constants shared by the io expander event router.
// ----------------------------------------------------------------------------
package iox_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_DEBOUNCE_MS     = 2'd0;
    localparam logic [1:0] CFG_SUPPRESS_MS     = 2'd1;
    localparam logic [1:0] CFG_LATCH_WINDOW_MS = 2'd2;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_MS_RST     = 16'd60;
    localparam logic [15:0] SUPPRESS_MS_RST     = 16'd200;
    localparam logic [15:0] LATCH_WINDOW_MS_RST = 16'd400;

    // port value with every input released
    localparam logic [7:0] PORT_RELEASED = 8'hFF;

    // bit positions on the active-low port
    localparam int unsigned BIT_TICK   = 0;
    localparam int unsigned BIT_BUTTON = 2;
    localparam int unsigned BIT_READER = 3;

    // one input beat
    typedef struct packed {
        logic        read_ok;
        logic [7:0]  port_inputs;
        logic [31:0] now_ms;
        logic        button_flow_blocked;
        logic        relay_busy;
        logic        recheck_ok;
        logic [7:0]  recheck_inputs;
    } t_iox_in;

    // one result beat
    typedef struct packed {
        logic       event_taken;
        logic       reader_ready;
        logic       second_tick;
        logic [1:0] button_release_count;
        logic       relay_pulse;
        logic       debounce_busy;
        logic [7:0] latest_inputs;
    } t_iox_out;

endpackage

// ----- hdl/io_expander_event_router.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_expander_event_router
// Routes input-port events to reader ready, second tick, button and relay.
// ----------------------------------------------------------------------------
// Each accepted event beat passes through an input register, a combinational
// decode against the router state, and a result register, which presents the
// result beat once the output side is ready. One event is taken every cycle
// while the output side is ready: the state update for an event is finished in
// the same cycle it is decoded, which the next event then sees. The output
// register holds a result while the consumer stalls, and the input register
// keeps one more event meanwhile. Configuration writes always complete in
// the cycle they are presented and must be made while no event is in flight.
module io_expander_event_router
    import iox_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // event input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_iox_in     i_in_data,

    // result output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_iox_out    o_out_data,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // pipeline registers
    logic     r_in_valid;
    t_iox_in  r_in_data;
    logic     r_out_valid;
    t_iox_out r_out_data;

    // configuration registers
    logic [15:0] r_debounce_ms;
    logic [15:0] r_suppress_ms;
    logic [15:0] r_latch_window_ms;

    // router state
    logic [7:0]  r_prev_inputs,   n_prev_inputs;
    logic [7:0]  r_latest_port,   n_latest_port;
    logic        r_deb_pending,   n_deb_pending;
    logic [31:0] r_deb_deadline,  n_deb_deadline;
    logic [31:0] r_suppress_until, n_suppress_until;
    logic        r_tick_latched,  n_tick_latched;
    logic [31:0] r_tick_time,     n_tick_time;

    t_iox_out    n_out_data;
    logic        w_adv;

    // decode intermediates
    logic        w_btn_changed;
    logic        w_skip;
    logic        w_new_start;
    logic        w_due;
    logic        w_rel_edge;
    logic        w_rel_check;
    logic [31:0] w_deb_diff;
    logic [31:0] w_sup_diff;
    logic [31:0] w_tick_diff;

    // handshake: decode advances when the result register can take a beat
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms     <= DEBOUNCE_MS_RST;
            r_suppress_ms     <= SUPPRESS_MS_RST;
            r_latch_window_ms <= LATCH_WINDOW_MS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:     r_debounce_ms     <= i_cfg_data;
                CFG_SUPPRESS_MS:     r_suppress_ms     <= i_cfg_data;
                CFG_LATCH_WINDOW_MS: r_latch_window_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    // wrap-safe time differences
    assign w_deb_diff  = r_in_data.now_ms - r_deb_deadline;
    assign w_sup_diff  = r_in_data.now_ms - r_suppress_until;
    assign w_tick_diff = r_in_data.now_ms - r_tick_time;

    // event decode and next state
    always_comb begin
        n_prev_inputs    = r_prev_inputs;
        n_latest_port    = r_latest_port;
        n_deb_pending    = r_deb_pending;
        n_deb_deadline   = r_deb_deadline;
        n_suppress_until = r_suppress_until;
        n_tick_latched   = r_tick_latched;
        n_tick_time      = r_tick_time;
        n_out_data       = '0;
        w_skip           = 1'b0;
        w_new_start      = 1'b0;
        w_due            = 1'b0;
        w_rel_edge       = 1'b0;
        w_rel_check      = 1'b0;
        w_btn_changed    = r_prev_inputs[BIT_BUTTON] ^ r_in_data.port_inputs[BIT_BUTTON];

        if (r_in_data.read_ok) begin
            n_latest_port = r_in_data.port_inputs;
            n_out_data.reader_ready = !r_in_data.port_inputs[BIT_READER];

            // button edge: release on high, debounce start unless blocked or already pending
            if (w_btn_changed) begin
                w_rel_edge = r_in_data.port_inputs[BIT_BUTTON];
                if (r_in_data.button_flow_blocked) begin
                    w_skip = 1'b1;
                end else if (!r_deb_pending) begin
                    w_new_start    = 1'b1;
                    n_deb_pending  = 1'b1;
                    n_deb_deadline = r_in_data.now_ms + {16'b0, r_debounce_ms};
                end
            end

            // a deadline set by this beat is already due only for a zero delay
            if (w_new_start) begin
                w_due = (r_debounce_ms == 16'd0);
            end else begin
                w_due = !w_deb_diff[31];
            end

            // deadline check on the re-read value
            if (!w_skip && n_deb_pending && w_due) begin
                n_deb_pending = 1'b0;
                if (r_in_data.recheck_ok) begin
                    n_latest_port = r_in_data.recheck_inputs;
                    if (r_in_data.recheck_inputs[BIT_BUTTON]) begin
                        w_rel_check = 1'b1;
                    end else if (!r_in_data.relay_busy && !w_sup_diff[31]) begin
                        n_out_data.relay_pulse = 1'b1;
                        n_suppress_until = r_in_data.now_ms + {16'b0, r_suppress_ms};
                    end
                end
            end

            // second tick latch
            if (!r_in_data.port_inputs[BIT_TICK]) begin
                if (!r_tick_latched) begin
                    n_out_data.second_tick = 1'b1;
                    n_tick_latched = 1'b1;
                    n_tick_time    = r_in_data.now_ms;
                end
            end else if (r_tick_latched && (w_tick_diff >= {16'b0, r_latch_window_ms})) begin
                n_tick_latched = 1'b0;
            end

            n_prev_inputs = r_in_data.port_inputs;
        end

        n_out_data.event_taken          = r_in_data.read_ok;
        n_out_data.button_release_count = {1'b0, w_rel_edge} + {1'b0, w_rel_check};
        n_out_data.debounce_busy        = n_deb_pending;
        n_out_data.latest_inputs        = n_latest_port;
    end

    // router state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_inputs    <= PORT_RELEASED;
            r_latest_port    <= PORT_RELEASED;
            r_deb_pending    <= 1'b0;
            r_deb_deadline   <= '0;
            r_suppress_until <= '0;
            r_tick_latched   <= 1'b0;
            r_tick_time      <= '0;
        end else if (w_adv) begin
            r_prev_inputs    <= n_prev_inputs;
            r_latest_port    <= n_latest_port;
            r_deb_pending    <= n_deb_pending;
            r_deb_deadline   <= n_deb_deadline;
            r_suppress_until <= n_suppress_until;
            r_tick_latched   <= n_tick_latched;
            r_tick_time      <= n_tick_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // a failed read leaves the router state alone
    a_failed_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_data.read_ok) |=>
            ($stable(r_latest_port) && $stable(r_deb_pending) && $stable(r_tick_latched)))
        else $error("failed read changed router state");

    // a pulse restarts the suppression window from the event time
    a_pulse_sets_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out_data.relay_pulse) |=>
            (r_suppress_until == ($past(r_in_data.now_ms) + {16'b0, $past(r_suppress_ms)})))
        else $error("suppression window not restarted by pulse");

    // a pulse always ends the pending debounce
    a_pulse_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.relay_pulse) |->
            (!o_out_data.debounce_busy && o_out_data.event_taken))
        else $error("pulse reported with debounce still pending");

    // a second tick leaves the latch set
    a_tick_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out_data.second_tick) |=> r_tick_latched)
        else $error("second tick without latch");
`endif

endmodule
